/* src/thfd_pkg.sv */
`default_nettype none
package thfd_pkg;

    // channel field widths
    localparam int COLOR_W = 8;
    localparam int FLAG_W  = 2;
    localparam int ADDR_W  = 16;
    localparam int PASS_W  = 10;
    localparam int FILL_W  = 16;
    localparam int DIM_W   = 9;
    localparam int KIND_W  = 2;
    localparam int CFGI_W  = 2;
    localparam int CFGD_W  = 10;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 56;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // pixel flags
    localparam logic [FLAG_W-1:0] FLAG_COLOR = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_HOLE  = 2'd1;

    // register indexes
    localparam logic [CFGI_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_PASSES = 2'd2;

    localparam logic [DIM_W-1:0]  RST_DIM    = 9'd256;
    localparam logic [PASS_W-1:0] RST_PASSES = 10'd500;

    // neighbor candidate codes, probed in this order
    localparam logic [2:0] CAND_LEFT  = 3'd0;
    localparam logic [2:0] CAND_RIGHT = 3'd1;
    localparam logic [2:0] CAND_UP    = 3'd2;
    localparam logic [2:0] CAND_DOWN  = 3'd3;
    localparam logic [2:0] CAND_SEAM  = 3'd4;
    localparam int NCAND = 5;

    // one memory word per pixel; fresh marks a fill in the pass of parity par
    typedef struct packed {
        logic [3*COLOR_W-1:0] color;
        logic [FLAG_W-1:0]    flag;
        logic                 fresh;
        logic                 par;
        logic                 seam_v;
        logic [ADDR_W-1:0]    seam_t;
    } t_pix;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_START,
        ST_SELF,
        ST_PROBE,
        ST_PASS_END,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

/* src/texture_hole_fill_dilation.sv */
// channel   | dir | handshake                   | payload
// ----------+-----+-----------------------------+---------------------------------------
// s_axis    | in  | tvalid/tready               | tuser kind, tdata pixel item
// m_axis    | out | tvalid/tready               | tdata pixel and run status
// cfg       | in  | we, no wait                 | idx 0 width, 1 height, 2 max_passes
//
// write items are answered directly from idle, read items after one ram read; one item at a time
// a run walks the image once per pass, one ram read per probed pixel
// a run that stops on the pass limit with fills in its last pass adds one
//   sweep that retires the per-pass fill marks
// synchronous active-low reset clears control only; pixel memory is undefined
// intake stays closed after reset or a register write until the derived pixel count has caught up
// a new item is taken only once the previous result has left the output register
`default_nettype none
module texture_hole_fill_dilation
    import thfd_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // address, red, green, blue, flag, seam_valid, seam_target, zero pad
    input  wire logic [S_DATA_W-1:0]   i_s_axis_tdata,
    // kind
    input  wire logic [KIND_W-1:0]     i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // out_red, out_green, out_blue, out_flag, passes_run, filled_total, zero pad
    output logic      [M_DATA_W-1:0]   o_m_axis_tdata,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFGI_W-1:0]     i_cfg_idx,
    input  wire logic [CFGD_W-1:0]     i_cfg_wdata
);

    localparam int PROD  = MAX_WIDTH * MAX_HEIGHT;
    localparam int DEPTH = (PROD > 65536) ? 65536 : PROD;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);
    localparam int CW    = (NW + 1 > ADDR_W + 1) ? NW + 1 : ADDR_W + 1;
    localparam int PW    = $bits(t_pix);

    // configuration
    logic [DIM_W-1:0]  r_width, r_height, r_ew, r_eh;
    logic [PASS_W-1:0] r_max;
    logic [NW-1:0]     r_n;
    logic [2*DIM_W-1:0] prod_wh;
    logic [1:0]        r_cfg_wait;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_DIM;
            r_height <= RST_DIM;
            r_max    <= RST_PASSES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:  r_width  <= i_cfg_wdata[DIM_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_wdata[DIM_W-1:0];
                CFG_PASSES: r_max    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // hold off intake until the derived pixel count has caught up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_cfg_wait <= 2'd2;
        end else if (r_cfg_wait != '0) begin
            r_cfg_wait <= r_cfg_wait - 1'b1;
        end
    end

    // saturated dimensions registered from the written values, then the pixel count registered from them
    assign prod_wh = r_ew * r_eh;

    always_ff @(posedge i_clk) begin
        if (r_width == '0) r_ew <= DIM_W'(1);
        else if (32'(r_width) > MAX_WIDTH) r_ew <= DIM_W'(MAX_WIDTH);
        else r_ew <= r_width;
        if (r_height == '0) r_eh <= DIM_W'(1);
        else if (32'(r_height) > MAX_HEIGHT) r_eh <= DIM_W'(MAX_HEIGHT);
        else r_eh <= r_height;
        if (32'(prod_wh) > DEPTH) r_n <= NW'(DEPTH);
        else r_n <= NW'(prod_wh);
    end

    // input fields
    logic [ADDR_W-1:0]    in_addr, in_seam_t;
    logic [3*COLOR_W-1:0] in_color;
    logic [FLAG_W-1:0]    in_flag;
    logic                 in_seam_v, in_ok, s_acc;

    assign in_addr   = i_s_axis_tdata[15:0];
    assign in_color  = {i_s_axis_tdata[23:16], i_s_axis_tdata[31:24], i_s_axis_tdata[39:32]};
    assign in_flag   = i_s_axis_tdata[41:40];
    assign in_seam_v = i_s_axis_tdata[42];
    assign in_seam_t = i_s_axis_tdata[58:43];
    assign in_ok     = CW'(in_addr) < CW'(r_n);

    // state
    t_state r_state, n_state;
    logic [NW-1:0]     r_i, n_i;
    logic [DIM_W-1:0]  r_x, n_x, r_y, n_y;
    logic [2:0]        r_cand, n_cand;
    t_pix              r_self, n_self;
    logic [PASS_W-1:0] r_pass, n_pass;
    logic [NW-1:0]     r_pfill, n_pfill;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_par, n_par, r_clean, n_clean, r_rd_ok, n_rd_ok;
    logic              r_ov, n_ov;
    logic [M_DATA_W-1:0] r_od, n_od;

    // memory port
    t_pix          q, wdata;
    logic          we;
    logic [AW-1:0] waddr, raddr;

    thfd_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_pix (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (q)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE) && !r_ov && (r_cfg_wait == '0);
    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_od;

    // pixel scan decisions
    logic            self_hole, stale, src_ok, seam_v_c, cand_found, adv, adv_last, fill_now;
    logic [ADDR_W-1:0] seam_t_c;
    logic [NCAND-1:0]  cv, cmask;
    logic [2:0]        cand_sel;
    logic [AW-1:0]     cand_addr;
    logic [CW-1:0]     i_ext;

    assign i_ext     = CW'(r_i);
    assign self_hole = (q.flag == FLAG_HOLE) && !r_clean;
    assign stale     = q.fresh && (q.par != r_par);
    // a source is colored and was not filled in the running pass
    assign src_ok    = (q.flag == FLAG_COLOR) && !(q.fresh && (q.par == r_par));
    assign seam_v_c  = (r_state == ST_SELF) ? q.seam_v : r_self.seam_v;
    assign seam_t_c  = (r_state == ST_SELF) ? q.seam_t : r_self.seam_t;

    assign cv[CAND_LEFT]  = (r_x != '0);
    assign cv[CAND_RIGHT] = ((DIM_W+1)'(r_x) + 1'b1 < (DIM_W+1)'(r_ew))
                            && (i_ext + 1'b1 < CW'(r_n));
    assign cv[CAND_UP]    = (r_y != '0);
    assign cv[CAND_DOWN]  = ((DIM_W+1)'(r_y) + 1'b1 < (DIM_W+1)'(r_eh))
                            && (i_ext + CW'(r_ew) < CW'(r_n));
    assign cv[CAND_SEAM]  = seam_v_c && (CW'(seam_t_c) < CW'(r_n));

    always_comb begin
        for (int k = 0; k < NCAND; k++) begin
            cmask[k] = (r_state == ST_SELF) || (3'(k) > r_cand);
        end
    end

    always_comb begin
        cand_found = 1'b0;
        cand_sel   = CAND_LEFT;
        for (int k = NCAND - 1; k >= 0; k--) begin
            if (cv[k] && cmask[k]) begin
                cand_found = 1'b1;
                cand_sel   = 3'(k);
            end
        end
    end

    always_comb begin
        case (cand_sel)
            CAND_LEFT:  cand_addr = AW'(r_i - 1'b1);
            CAND_RIGHT: cand_addr = AW'(r_i + 1'b1);
            CAND_UP:    cand_addr = AW'(i_ext - CW'(r_ew));
            CAND_DOWN:  cand_addr = AW'(i_ext + CW'(r_ew));
            default:    cand_addr = AW'(seam_t_c);
        endcase
    end

    assign adv = ((r_state == ST_SELF) && (!self_hole || !cand_found))
              || ((r_state == ST_PROBE) && (src_ok || !cand_found));
    assign adv_last = (i_ext + 1'b1) >= CW'(r_n);
    assign fill_now = (r_state == ST_PROBE) && src_ok;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    if (i_s_axis_tuser == KIND_RUN) begin
                        n_state = (r_max == '0) ? ST_DONE : ST_START;
                    end else if (i_s_axis_tuser == KIND_READ) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ:  n_state = ST_IDLE;
            ST_START: n_state = ST_SELF;
            ST_SELF, ST_PROBE: begin
                if (adv) n_state = adv_last ? ST_PASS_END : ST_SELF;
                else n_state = ST_PROBE;
            end
            ST_PASS_END: begin
                if (r_clean || r_pfill == '0) n_state = ST_DONE;
                else n_state = ST_START;
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    logic [FILL_W+1:0] fill_sum;
    assign fill_sum = (FILL_W+2)'(r_fill) + (FILL_W+2)'(r_pfill);

    // datapath and memory control
    always_comb begin
        n_i = r_i; n_x = r_x; n_y = r_y; n_cand = r_cand; n_self = r_self;
        n_pass = r_pass; n_pfill = r_pfill; n_fill = r_fill; n_par = r_par;
        n_clean = r_clean; n_rd_ok = r_rd_ok;
        n_ov = r_ov && !i_m_axis_tready; n_od = r_od;
        we = 1'b0; waddr = AW'(r_i); wdata = q; raddr = '0;

        unique case (r_state)
            ST_IDLE: begin
                raddr = AW'(in_addr);
                if (s_acc) begin
                    n_rd_ok = in_ok;
                    if (i_s_axis_tuser == KIND_WRITE && in_ok) begin
                        we    = 1'b1;
                        waddr = AW'(in_addr);
                        wdata = '{color: in_color, flag: in_flag, fresh: 1'b0, par: 1'b0,
                                  seam_v: in_seam_v, seam_t: in_seam_t};
                    end
                    if (i_s_axis_tuser == KIND_RUN) begin
                        n_pass  = '0;
                        n_fill  = '0;
                        n_clean = 1'b0;
                    end else if (i_s_axis_tuser != KIND_READ) begin
                        n_ov = 1'b1;
                        n_od = M_DATA_W'({r_fill, r_pass, FLAG_W'(0), (3*COLOR_W)'(0)});
                    end
                end
            end
            ST_READ: begin
                n_ov = 1'b1;
                if (r_rd_ok) begin
                    n_od = M_DATA_W'({r_fill, r_pass, q.flag, q.color[7:0], q.color[15:8],
                                      q.color[23:16]});
                end else begin
                    n_od = M_DATA_W'({r_fill, r_pass, FLAG_W'(0), (3*COLOR_W)'(0)});
                end
            end
            ST_START: begin
                raddr   = '0;
                n_i     = '0;
                n_x     = '0;
                n_y     = '0;
                n_pfill = '0;
                n_par   = !r_par;
                if (!r_clean) n_pass = r_pass + 1'b1;
            end
            ST_SELF, ST_PROBE: begin
                if (r_state == ST_SELF) begin
                    n_self = q;
                    // retire a fill mark left by the previous pass
                    if (stale) begin
                        we          = 1'b1;
                        wdata.fresh = 1'b0;
                    end
                end
                if (fill_now) begin
                    we    = 1'b1;
                    wdata = '{color: q.color, flag: FLAG_COLOR, fresh: 1'b1, par: r_par,
                              seam_v: r_self.seam_v, seam_t: r_self.seam_t};
                    n_pfill = r_pfill + 1'b1;
                end
                if (adv) begin
                    raddr = AW'(r_i + 1'b1);
                    n_i   = r_i + 1'b1;
                    if ((DIM_W+1)'(r_x) + 1'b1 == (DIM_W+1)'(r_ew)) begin
                        n_x = '0;
                        n_y = r_y + 1'b1;
                    end else begin
                        n_x = r_x + 1'b1;
                    end
                end else begin
                    raddr  = cand_addr;
                    n_cand = cand_sel;
                end
            end
            ST_PASS_END: begin
                if (!r_clean) begin
                    n_fill  = (fill_sum > (FILL_W+2)'({FILL_W{1'b1}})) ? {FILL_W{1'b1}}
                                                                      : FILL_W'(fill_sum);
                    n_clean = (r_pfill != '0) && (r_pass == r_max);
                end
            end
            ST_DONE: begin
                n_ov = 1'b1;
                n_od = M_DATA_W'({r_fill, r_pass, FLAG_W'(0), (3*COLOR_W)'(0)});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_pass  <= '0;
            r_fill  <= '0;
            r_par   <= 1'b0;
            r_clean <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_pass  <= n_pass;
            r_fill  <= n_fill;
            r_par   <= n_par;
            r_clean <= n_clean;
        end
        r_i     <= n_i;
        r_x     <= n_x;
        r_y     <= n_y;
        r_cand  <= n_cand;
        r_self  <= n_self;
        r_pfill <= n_pfill;
        r_rd_ok <= n_rd_ok;
        r_od    <= n_od;
    end

endmodule
`default_nettype wire

/* src/thfd_ram.sv */
`default_nettype none
module thfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* src/thfd_checker.sv */
`default_nettype none
module thfd_checker
    import thfd_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_s_axis_tvalid,
    input wire logic                o_s_axis_tready,
    input wire logic                o_m_axis_tvalid,
    input wire logic                i_m_axis_tready,
    input wire logic [M_DATA_W-1:0] o_m_axis_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // one item in flight: no intake while a result waits
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !o_m_axis_tvalid)
        else $error("input ready with a result pending");

    // after a transaction the intake closes
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second item taken before result");

    // reset empties the output
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind texture_hole_fill_dilation thfd_checker u_thfd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire
